// ----- rtl/spi_nor_flash_command_sequencer_unit_assert.svh -----
// ============================================================================
// Assertion macros for the SPI NOR flash command sequencer
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ============================================================================
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_ASSERT_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define SNFCS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define SNFCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SNFCS_ASSERT_IMP(label, ante, cons, msg)
`define SNFCS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/snfcs_pkg.sv -----
// ============================================================================
// snfcs_pkg
// Shared types, codes and constants of the SPI NOR flash command sequencer.
// ============================================================================
package snfcs_pkg;

   // Sizing defaults.
   localparam int PAGE_BYTES_DEFAULT = 256;
   localparam int QUEUE_DEPTH        = 4;
   localparam int ADDR_BYTES         = 3;
   localparam int ID_BYTES           = 3;

   // Request modes.
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_XFER  = 2'd2;

   // Host operations.
   localparam logic [2:0] OP_ID     = 3'd0;
   localparam logic [2:0] OP_WAIT   = 3'd1;
   localparam logic [2:0] OP_WREN   = 3'd2;
   localparam logic [2:0] OP_SERASE = 3'd3;
   localparam logic [2:0] OP_PROG   = 3'd4;
   localparam logic [2:0] OP_CERASE = 3'd5;
   localparam logic [2:0] OP_READ   = 3'd6;

   // Flash command bytes.
   localparam logic [7:0] CMD_RDID  = 8'h9F;
   localparam logic [7:0] CMD_RDSR  = 8'h05;
   localparam logic [7:0] CMD_WREN  = 8'h06;
   localparam logic [7:0] CMD_SE    = 8'h20;
   localparam logic [7:0] CMD_PP    = 8'h02;
   localparam logic [7:0] CMD_CE    = 8'hC7;
   localparam logic [7:0] CMD_READ  = 8'h03;

   localparam logic [7:0] DUMMY_RESET = 8'hFF;
   localparam int         STATUS_BUSY_BIT = 0;

   // Result kinds.
   typedef enum logic [2:0] {
      KIND_SEND    = 3'd0,
      KIND_RELEASE = 3'd1,
      KIND_HOST    = 3'd2,
      KIND_DONE    = 3'd3,
      KIND_REJECT  = 3'd4
   } kind_type;

   // Sequencer phases.
   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_WREN  = 4'd1,
      PH_CMD   = 4'd2,
      PH_ADDR  = 4'd3,
      PH_PDATA = 4'd4,
      PH_RDATA = 4'd5,
      PH_IDB   = 4'd6,
      PH_STAT  = 4'd7,
      PH_POLL  = 4'd8
   } phase_type;

   // One result item.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
   } slot_type;

   // All results of one request transaction, slot 0 goes out first.
   typedef struct packed {
      logic [1:0]     count;
      slot_type [2:0] slot;
   } action_type;

   // Queue entry as it moves between the front and the back.
   typedef struct packed {
      logic       valid;
      action_type action;
   } entry_type;

endpackage

// ----- rtl/snfcs_front.sv -----
// ============================================================================
// snfcs_front
// Accepts requests, runs the command sequence and queues the results.
// ============================================================================
`include "spi_nor_flash_command_sequencer_unit_assert.svh"

module snfcs_front #(
   parameter int PAGE_BYTES = snfcs_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_mode,
   input  logic [2:0]            req_operation,
   input  logic [23:0]           req_flash_address,
   input  logic [24:0]           req_byte_count,
   input  logic [7:0]            req_data_byte,
   input  logic                  csr_we,
   input  logic [7:0]            csr_wdata,
   input  logic                  q_full,
   output snfcs_pkg::entry_type  push
);

   localparam int IdxW = $clog2(PAGE_BYTES);
   localparam int CntW = $clog2(PAGE_BYTES + 1);
   localparam logic [CntW-1:0] PageCnt  = CntW'(PAGE_BYTES);
   localparam logic [24:0]     PageLen  = 25'(PAGE_BYTES);
   localparam logic [CntW-1:0] AddrEnd  = CntW'(snfcs_pkg::ADDR_BYTES);
   localparam logic [CntW-1:0] IdMore   = CntW'(snfcs_pkg::ID_BYTES - 1);
   localparam logic [CntW-1:0] CntOne   = CntW'(1);

   snfcs_pkg::phase_type phase_ff, phase_in;
   logic [2:0]           op_ff, op_in;
   logic [23:0]          addr_ff, addr_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [24:0]          rem_ff, rem_in;
   logic [7:0]           dummy_ff, dummy_in;
   logic [7:0]           page_buf_ff [PAGE_BYTES];
   logic [7:0]           rd_data_ff;
   logic [IdxW-1:0]      rd_idx;
   logic                 mem_we;

   logic fire, is_start, is_load, is_xfer, start_ok;
   logic addr_more, rem_nz, pdata_more, idb_more, busy;
   logic [7:0] addr_byte, first_cmd;
   snfcs_pkg::action_type act;

   function automatic snfcs_pkg::slot_type mk(snfcs_pkg::kind_type k, logic [7:0] v);
      snfcs_pkg::slot_type s;
      s.kind  = k;
      s.value = v;
      return s;
   endfunction

   function automatic snfcs_pkg::action_type act_n(logic [1:0] n, snfcs_pkg::slot_type a,
                                                   snfcs_pkg::slot_type b,
                                                   snfcs_pkg::slot_type c);
      snfcs_pkg::action_type r;
      r.count   = n;
      r.slot[0] = a;
      r.slot[1] = b;
      r.slot[2] = c;
      return r;
   endfunction

   // A request is taken whenever the result queue has room.
   assign req_tready = !q_full;
   assign fire       = req_tvalid && !q_full;
   assign is_start   = fire && (req_mode == snfcs_pkg::MODE_START);
   assign is_load    = fire && (req_mode == snfcs_pkg::MODE_LOAD);
   assign is_xfer    = fire && (req_mode == snfcs_pkg::MODE_XFER) &&
                       (phase_ff != snfcs_pkg::PH_IDLE);

   // Shared decisions of the sequence.
   assign start_ok   = (phase_ff == snfcs_pkg::PH_IDLE) &&
                       (req_operation <= snfcs_pkg::OP_READ) &&
                       !((req_operation == snfcs_pkg::OP_PROG) && (req_byte_count > PageLen));
   assign addr_more  = cnt_ff < AddrEnd;
   assign rem_nz     = rem_ff != 25'd0;
   assign pdata_more = (25'(cnt_ff) < rem_ff) && (cnt_ff < PageCnt);
   assign idb_more   = cnt_ff < IdMore;
   assign busy       = req_data_byte[snfcs_pkg::STATUS_BUSY_BIT];
   assign addr_byte  = (cnt_ff == CntOne) ? addr_ff[15:8] : addr_ff[7:0];

   // First command byte of a new operation.
   always_comb begin
      case (req_operation)
         snfcs_pkg::OP_ID:   first_cmd = snfcs_pkg::CMD_RDID;
         snfcs_pkg::OP_WAIT: first_cmd = snfcs_pkg::CMD_RDSR;
         snfcs_pkg::OP_READ: first_cmd = snfcs_pkg::CMD_READ;
         default:            first_cmd = snfcs_pkg::CMD_WREN;
      endcase
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (is_start && start_ok) begin
         case (req_operation)
            snfcs_pkg::OP_ID:   phase_in = snfcs_pkg::PH_CMD;
            snfcs_pkg::OP_WAIT: phase_in = snfcs_pkg::PH_STAT;
            snfcs_pkg::OP_READ: phase_in = snfcs_pkg::PH_CMD;
            default:            phase_in = snfcs_pkg::PH_WREN;
         endcase
      end else if (is_xfer) begin
         case (phase_ff)
            snfcs_pkg::PH_WREN: begin
               phase_in = (op_ff == snfcs_pkg::OP_WREN) ? snfcs_pkg::PH_IDLE
                                                        : snfcs_pkg::PH_CMD;
            end
            snfcs_pkg::PH_CMD: begin
               if (op_ff == snfcs_pkg::OP_ID)
                  phase_in = snfcs_pkg::PH_IDB;
               else if (op_ff == snfcs_pkg::OP_SERASE || op_ff == snfcs_pkg::OP_PROG ||
                        op_ff == snfcs_pkg::OP_READ)
                  phase_in = snfcs_pkg::PH_ADDR;
               else if (op_ff == snfcs_pkg::OP_CERASE)
                  phase_in = snfcs_pkg::PH_STAT;
               else
                  phase_in = snfcs_pkg::PH_IDLE;
            end
            snfcs_pkg::PH_ADDR: begin
               if (!addr_more) begin
                  if (op_ff == snfcs_pkg::OP_PROG)
                     phase_in = rem_nz ? snfcs_pkg::PH_PDATA : snfcs_pkg::PH_STAT;
                  else if (op_ff == snfcs_pkg::OP_READ)
                     phase_in = rem_nz ? snfcs_pkg::PH_RDATA : snfcs_pkg::PH_IDLE;
                  else
                     phase_in = snfcs_pkg::PH_STAT;
               end
            end
            snfcs_pkg::PH_PDATA: if (!pdata_more) phase_in = snfcs_pkg::PH_STAT;
            snfcs_pkg::PH_RDATA: if (!rem_nz) phase_in = snfcs_pkg::PH_IDLE;
            snfcs_pkg::PH_IDB:   if (!idb_more) phase_in = snfcs_pkg::PH_IDLE;
            snfcs_pkg::PH_STAT:  phase_in = snfcs_pkg::PH_POLL;
            snfcs_pkg::PH_POLL:  if (!busy) phase_in = snfcs_pkg::PH_IDLE;
            default:             phase_in = phase_ff;
         endcase
      end
   end

   // Results and operand registers.
   always_comb begin
      snfcs_pkg::slot_type s_none, s_rel, s_done, s_stat, s_dummy, s_host;
      s_none  = mk(snfcs_pkg::KIND_SEND, 8'd0);
      s_rel   = mk(snfcs_pkg::KIND_RELEASE, 8'd0);
      s_done  = mk(snfcs_pkg::KIND_DONE, 8'd0);
      s_stat  = mk(snfcs_pkg::KIND_SEND, snfcs_pkg::CMD_RDSR);
      s_dummy = mk(snfcs_pkg::KIND_SEND, dummy_ff);
      s_host  = mk(snfcs_pkg::KIND_HOST, req_data_byte);

      act     = '0;
      op_in   = op_ff;
      addr_in = addr_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      mem_we  = 1'b0;

      if (is_start) begin
         if (!start_ok) begin
            act = act_n(2'd1, mk(snfcs_pkg::KIND_REJECT, 8'd0), s_none, s_none);
         end else begin
            op_in   = req_operation;
            addr_in = req_flash_address;
            rem_in  = req_byte_count;
            cnt_in  = '0;
            act     = act_n(2'd1, mk(snfcs_pkg::KIND_SEND, first_cmd), s_none, s_none);
         end
      end else if (is_load) begin
         if (phase_ff == snfcs_pkg::PH_IDLE && cnt_ff < PageCnt) begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + CntOne;
         end
      end else if (is_xfer) begin
         case (phase_ff)
            snfcs_pkg::PH_WREN: begin
               if (op_ff == snfcs_pkg::OP_WREN) begin
                  act    = act_n(2'd2, s_rel, s_done, s_none);
                  cnt_in = '0;
               end else if (op_ff == snfcs_pkg::OP_SERASE) begin
                  act = act_n(2'd2, s_rel, mk(snfcs_pkg::KIND_SEND, snfcs_pkg::CMD_SE), s_none);
               end else if (op_ff == snfcs_pkg::OP_PROG) begin
                  act = act_n(2'd2, s_rel, mk(snfcs_pkg::KIND_SEND, snfcs_pkg::CMD_PP), s_none);
               end else begin
                  act = act_n(2'd2, s_rel, mk(snfcs_pkg::KIND_SEND, snfcs_pkg::CMD_CE), s_none);
               end
            end
            snfcs_pkg::PH_CMD: begin
               if (op_ff == snfcs_pkg::OP_ID) begin
                  cnt_in = '0;
                  act    = act_n(2'd1, s_dummy, s_none, s_none);
               end else if (op_ff == snfcs_pkg::OP_SERASE || op_ff == snfcs_pkg::OP_PROG ||
                            op_ff == snfcs_pkg::OP_READ) begin
                  cnt_in = CntOne;
                  act    = act_n(2'd1, mk(snfcs_pkg::KIND_SEND, addr_ff[23:16]), s_none, s_none);
               end else if (op_ff == snfcs_pkg::OP_CERASE) begin
                  act = act_n(2'd2, s_rel, s_stat, s_none);
               end else begin
                  act    = act_n(2'd2, s_rel, s_done, s_none);
                  cnt_in = '0;
               end
            end
            snfcs_pkg::PH_ADDR: begin
               if (addr_more) begin
                  act    = act_n(2'd1, mk(snfcs_pkg::KIND_SEND, addr_byte), s_none, s_none);
                  cnt_in = cnt_ff + CntOne;
               end else if (op_ff == snfcs_pkg::OP_PROG) begin
                  if (rem_nz) begin
                     cnt_in = CntOne;
                     act    = act_n(2'd1, mk(snfcs_pkg::KIND_SEND, rd_data_ff), s_none, s_none);
                  end else begin
                     act = act_n(2'd2, s_rel, s_stat, s_none);
                  end
               end else if (op_ff == snfcs_pkg::OP_READ) begin
                  if (rem_nz) begin
                     rem_in = rem_ff - 25'd1;
                     act    = act_n(2'd1, s_dummy, s_none, s_none);
                  end else begin
                     act    = act_n(2'd2, s_rel, s_done, s_none);
                     cnt_in = '0;
                  end
               end else begin
                  act = act_n(2'd2, s_rel, s_stat, s_none);
               end
            end
            snfcs_pkg::PH_PDATA: begin
               if (pdata_more) begin
                  act    = act_n(2'd1, mk(snfcs_pkg::KIND_SEND, rd_data_ff), s_none, s_none);
                  cnt_in = cnt_ff + CntOne;
               end else begin
                  act = act_n(2'd2, s_rel, s_stat, s_none);
               end
            end
            snfcs_pkg::PH_RDATA: begin
               if (rem_nz) begin
                  rem_in = rem_ff - 25'd1;
                  act    = act_n(2'd2, s_host, s_dummy, s_none);
               end else begin
                  act    = act_n(2'd3, s_host, s_rel, s_done);
                  cnt_in = '0;
               end
            end
            snfcs_pkg::PH_IDB: begin
               if (idb_more) begin
                  cnt_in = cnt_ff + CntOne;
                  act    = act_n(2'd2, s_host, s_dummy, s_none);
               end else begin
                  cnt_in = '0;
                  act    = act_n(2'd3, s_host, s_rel, s_done);
               end
            end
            snfcs_pkg::PH_STAT: begin
               act = act_n(2'd1, s_dummy, s_none, s_none);
            end
            snfcs_pkg::PH_POLL: begin
               if (busy) begin
                  act = act_n(2'd1, s_dummy, s_none, s_none);
               end else begin
                  act    = act_n(2'd2, s_rel, s_done, s_none);
                  cnt_in = '0;
               end
            end
            default: act = '0;
         endcase
      end
   end

   assign push.valid  = act.count != 2'd0;
   assign push.action = act;

   // The filler byte register.
   assign dummy_in = csr_we ? csr_wdata : dummy_ff;

   // Control and operand registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= snfcs_pkg::PH_IDLE;
         op_ff    <= '0;
         addr_ff  <= '0;
         cnt_ff   <= '0;
         rem_ff   <= '0;
         dummy_ff <= snfcs_pkg::DUMMY_RESET;
      end else begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         addr_ff  <= addr_in;
         cnt_ff   <= cnt_in;
         rem_ff   <= rem_in;
         dummy_ff <= dummy_in;
      end
   end

   // Page buffer: the read port always fetches the entry the next program
   // byte will need, so the data is ready when the exchange completes.
   assign rd_idx = (phase_in == snfcs_pkg::PH_PDATA) ? cnt_in[IdxW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_buf_ff[cnt_ff[IdxW-1:0]] <= req_data_byte;
      end
      rd_data_ff <= page_buf_ff[rd_idx];
   end

   `SNFCS_ASSERT_IMP(a_idle_ptr_range, phase_ff == snfcs_pkg::PH_IDLE, cnt_ff <= PageCnt,
                     "load pointer beyond page size")
   `SNFCS_ASSERT_IMP(a_addr_count, phase_ff == snfcs_pkg::PH_ADDR,
                     cnt_ff >= CntOne && cnt_ff <= AddrEnd, "address byte count out of range")
   `SNFCS_ASSERT_IMP(a_pdata_prog, phase_ff == snfcs_pkg::PH_PDATA,
                     op_ff == snfcs_pkg::OP_PROG && rem_ff <= PageLen,
                     "program data phase outside a valid program")

endmodule

// ----- rtl/snfcs_queue.sv -----
// ============================================================================
// snfcs_queue
// Short queue of result groups between the sequencer and the result stage.
// ============================================================================
module snfcs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  snfcs_pkg::entry_type  push,
   input  logic                  pop,
   output snfcs_pkg::entry_type  head,
   output logic                  full
);

   localparam int PtrW = $clog2(snfcs_pkg::QUEUE_DEPTH);
   localparam int CntW = $clog2(snfcs_pkg::QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(snfcs_pkg::QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] Depth   = CntW'(snfcs_pkg::QUEUE_DEPTH);

   snfcs_pkg::action_type entries_ff [snfcs_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full        = count_ff == Depth;
   assign head.valid  = count_ff != '0;
   assign head.action = entries_ff[rd_ptr_ff];
   assign do_push     = push.valid && !full;
   assign do_pop      = pop && head.valid;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
      if (do_push && !do_pop)      count_in = count_ff + CntW'(1);
      else if (!do_push && do_pop) count_in = count_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.action;
      end
   end

endmodule

// ----- rtl/snfcs_back.sv -----
// ============================================================================
// snfcs_back
// Result stage: sends the results of each queued group one per transaction.
// ============================================================================
`include "spi_nor_flash_command_sequencer_unit_assert.svh"

module snfcs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  snfcs_pkg::entry_type  head,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [2:0]            rsp_kind,
   output logic [7:0]            rsp_byte_value,
   output logic                  rsp_last
);

   snfcs_pkg::action_type cur_ff, cur_in;
   logic [1:0]            idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   snfcs_pkg::slot_type   sel;
   logic                  fire, group_done;

   assign sel            = cur_ff.slot[idx_ff];
   assign rsp_tvalid     = valid_ff;
   assign rsp_kind       = sel.kind;
   assign rsp_byte_value = sel.value;
   assign rsp_last       = idx_ff == (cur_ff.count - 2'd1);

   assign fire       = valid_ff && rsp_tready;
   assign group_done = fire && rsp_last;
   assign pop        = head.valid && (!valid_ff || group_done);

   // Load the next group when the stage is empty or as the current one finishes.
   always_comb begin
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (pop) begin
         cur_in   = head.action;
         idx_in   = '0;
         valid_in = 1'b1;
      end else if (group_done) begin
         valid_in = 1'b0;
      end else if (fire) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   `SNFCS_ASSERT_IMP(a_group_nonempty, valid_ff, cur_ff.count != 2'd0,
                     "empty result group in the output stage")
   `SNFCS_ASSERT_IMP(a_index_range, valid_ff, idx_ff < cur_ff.count,
                     "result index past the end of its group")
   `SNFCS_ASSERT_NEXT(a_pop_loads, pop, valid_ff && idx_ff == 2'd0,
                      "popped group not loaded at its first result")

endmodule

// ----- rtl/spi_nor_flash_command_sequencer_unit.sv -----
// ============================================================================
// spi_nor_flash_command_sequencer_unit
// Byte-level command sequencer for a SPI NOR flash.
// ============================================================================
// Usage: the req_ stream carries host commands (start an operation, load a
// program data byte into the page buffer) and SPI byte-completion events with
// the received byte. Each request transaction causes zero to three result
// transactions on the rsp_ stream: a byte to send with select low, a select
// release, a byte for the host, done or rejected; rsp_tlast marks the last
// result of a request. csr_we writes the filler byte used to clock in data.
// Timing: the first result of a request is written into the result queue,
// then loaded into the output stage register before it is presented. A request is
// accepted in every cycle in which the four-entry result queue has room, so
// one request per cycle is sustained; results leave at one per cycle while the
// receiver is ready, so requests with several results limit the rate to one
// result per cycle at the output stage.
// Reset clears the sequencer to idle, empties the queue and sets the filler
// byte to 0xFF; the page buffer holds no defined contents until loaded.
// When the receiver stalls, results wait in the output stage and the queue;
// once the queue is full, req_tready drops until an entry leaves.
// ============================================================================
module spi_nor_flash_command_sequencer_unit #(
   parameter int PAGE_BYTES = snfcs_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: operation[2:0], flash_address[26:3], byte_count[51:27],
   // data_byte[59:52], zero padding[63:60]
   input  logic [63:0] req_tdata,
   // tuser: mode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: byte_value[7:0]
   output logic [7:0]  rsp_tdata,
   // tuser: kind[2:0]
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   snfcs_pkg::entry_type push, head;
   logic                 q_full, pop;

   // Sequencer front: decodes requests and builds result groups.
   snfcs_front #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_mode          (req_tuser),
      .req_operation     (req_tdata[2:0]),
      .req_flash_address (req_tdata[26:3]),
      .req_byte_count    (req_tdata[51:27]),
      .req_data_byte     (req_tdata[59:52]),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .q_full            (q_full),
      .push              (push)
   );

   // Result group queue.
   snfcs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   // Output stage.
   snfcs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_kind       (rsp_tuser),
      .rsp_byte_value (rsp_tdata),
      .rsp_last       (rsp_tlast)
   );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the SPI NOR flash command sequencer
// A predictor tracks the sequencer state and queues the expected results of
// every accepted request transaction. A checker compares each response
// transaction against the oldest expectation. Directed tests cover each
// operation and corner case, then random well-formed flash sequences mixed
// with noise run under three settings of back-pressure and source gaps.
// ----------------------------------------------------------------------------
module tb;

   localparam int PAGE_DEPTH   = snfcs_pkg::PAGE_BYTES_DEFAULT;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE_TICKS = 8;

   // Codes with no name in the package.
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [2:0] OP_UNUSED  = 3'd7;

   typedef struct {
      snfcs_pkg::kind_type kind;
      logic [7:0]          value;
      logic                last;
   } flash_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [7:0]  csr_wdata;

   // Predicted sequencer state.
   snfcs_pkg::phase_type seq_phase;
   logic [2:0]           seq_op;
   logic [23:0]          seq_addr;
   logic [24:0]          seq_index;
   logic [24:0]          seq_left;
   logic [7:0]           page_mem [PAGE_DEPTH];
   logic [7:0]           filler_byte;
   int                   filled_len;

   flash_result_type expected_results[$];
   int               error_count;
   int               effective_items;
   int               idle_cycles;
   int               send_idle_pct;
   int               recv_idle_pct;

   spi_nor_flash_command_sequencer_unit #(
      .PAGE_BYTES(PAGE_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic void add_result(input snfcs_pkg::kind_type kind,
                                      input logic [7:0] value);
      flash_result_type item;
      item.kind  = kind;
      item.value = value;
      item.last  = 1'b0;
      expected_results.push_back(item);
   endfunction

   function automatic void close_sequence();
      add_result(snfcs_pkg::KIND_RELEASE, 8'h00);
      add_result(snfcs_pkg::KIND_DONE, 8'h00);
      seq_phase = snfcs_pkg::PH_IDLE;
      seq_index = '0;
   endfunction

   function automatic void goto_status();
      add_result(snfcs_pkg::KIND_RELEASE, 8'h00);
      add_result(snfcs_pkg::KIND_SEND, snfcs_pkg::CMD_RDSR);
      seq_phase = snfcs_pkg::PH_STAT;
   endfunction

   function automatic void start_operation(input logic [2:0] op, input logic [23:0] addr,
                                           input logic [24:0] count);
      if (seq_phase != snfcs_pkg::PH_IDLE || op == OP_UNUSED ||
          (op == snfcs_pkg::OP_PROG && count > PAGE_DEPTH)) begin
         add_result(snfcs_pkg::KIND_REJECT, 8'h00);
      end else begin
         seq_op    = op;
         seq_addr  = addr;
         seq_left  = count;
         seq_index = '0;
         case (op)
            snfcs_pkg::OP_ID: begin
               add_result(snfcs_pkg::KIND_SEND, snfcs_pkg::CMD_RDID);
               seq_phase = snfcs_pkg::PH_CMD;
            end
            snfcs_pkg::OP_WAIT: begin
               add_result(snfcs_pkg::KIND_SEND, snfcs_pkg::CMD_RDSR);
               seq_phase = snfcs_pkg::PH_STAT;
            end
            snfcs_pkg::OP_READ: begin
               add_result(snfcs_pkg::KIND_SEND, snfcs_pkg::CMD_READ);
               seq_phase = snfcs_pkg::PH_CMD;
            end
            default: begin
               add_result(snfcs_pkg::KIND_SEND, snfcs_pkg::CMD_WREN);
               seq_phase = snfcs_pkg::PH_WREN;
            end
         endcase
      end
   endfunction

   // One completed SPI byte exchange while an operation runs.
   function automatic void exchange_completed(input logic [7:0] rx);
      int shift;
      case (seq_phase)
         snfcs_pkg::PH_WREN: begin
            if (seq_op == snfcs_pkg::OP_WREN) begin
               close_sequence();
            end else begin
               add_result(snfcs_pkg::KIND_RELEASE, 8'h00);
               add_result(snfcs_pkg::KIND_SEND,
                          (seq_op == snfcs_pkg::OP_SERASE) ? snfcs_pkg::CMD_SE :
                          (seq_op == snfcs_pkg::OP_PROG) ? snfcs_pkg::CMD_PP :
                          snfcs_pkg::CMD_CE);
               seq_phase = snfcs_pkg::PH_CMD;
            end
         end
         snfcs_pkg::PH_CMD: begin
            if (seq_op == snfcs_pkg::OP_ID) begin
               seq_index = '0;
               seq_phase = snfcs_pkg::PH_IDB;
               add_result(snfcs_pkg::KIND_SEND, filler_byte);
            end else if (seq_op == snfcs_pkg::OP_SERASE || seq_op == snfcs_pkg::OP_PROG ||
                         seq_op == snfcs_pkg::OP_READ) begin
               seq_index = 25'd1;
               seq_phase = snfcs_pkg::PH_ADDR;
               add_result(snfcs_pkg::KIND_SEND, seq_addr[23:16]);
            end else if (seq_op == snfcs_pkg::OP_CERASE) begin
               goto_status();
            end else begin
               close_sequence();
            end
         end
         snfcs_pkg::PH_ADDR: begin
            if (seq_index < snfcs_pkg::ADDR_BYTES) begin
               shift = 8 * (snfcs_pkg::ADDR_BYTES - 1 - int'(seq_index));
               add_result(snfcs_pkg::KIND_SEND, 8'(seq_addr >> shift));
               seq_index++;
            end else if (seq_op == snfcs_pkg::OP_PROG) begin
               if (seq_left > 0) begin
                  seq_index = 25'd1;
                  seq_phase = snfcs_pkg::PH_PDATA;
                  add_result(snfcs_pkg::KIND_SEND, page_mem[0]);
               end else begin
                  goto_status();
               end
            end else if (seq_op == snfcs_pkg::OP_READ) begin
               if (seq_left > 0) begin
                  seq_left--;
                  seq_phase = snfcs_pkg::PH_RDATA;
                  add_result(snfcs_pkg::KIND_SEND, filler_byte);
               end else begin
                  close_sequence();
               end
            end else begin
               goto_status();
            end
         end
         snfcs_pkg::PH_PDATA: begin
            if (seq_index < seq_left && seq_index < PAGE_DEPTH) begin
               add_result(snfcs_pkg::KIND_SEND, page_mem[seq_index]);
               seq_index++;
            end else begin
               goto_status();
            end
         end
         snfcs_pkg::PH_RDATA: begin
            add_result(snfcs_pkg::KIND_HOST, rx);
            if (seq_left > 0) begin
               seq_left--;
               add_result(snfcs_pkg::KIND_SEND, filler_byte);
            end else begin
               close_sequence();
            end
         end
         snfcs_pkg::PH_IDB: begin
            add_result(snfcs_pkg::KIND_HOST, rx);
            seq_index++;
            if (seq_index < snfcs_pkg::ID_BYTES) begin
               add_result(snfcs_pkg::KIND_SEND, filler_byte);
            end else begin
               close_sequence();
            end
         end
         snfcs_pkg::PH_STAT: begin
            seq_phase = snfcs_pkg::PH_POLL;
            add_result(snfcs_pkg::KIND_SEND, filler_byte);
         end
         snfcs_pkg::PH_POLL: begin
            if (rx[snfcs_pkg::STATUS_BUSY_BIT]) begin
               add_result(snfcs_pkg::KIND_SEND, filler_byte);
            end else begin
               close_sequence();
            end
         end
         default: ;
      endcase
   endfunction

   // Returns 1 when the transaction changed state or caused results.
   function automatic bit predict_item(input logic [1:0] mode, input logic [2:0] op,
                                       input logic [23:0] addr, input logic [24:0] count,
                                       input logic [7:0] data);
      int  prior;
      bit  effective;
      prior     = expected_results.size();
      effective = 1'b0;
      case (mode)
         snfcs_pkg::MODE_START: start_operation(op, addr, count);
         snfcs_pkg::MODE_LOAD: begin
            if (seq_phase == snfcs_pkg::PH_IDLE && seq_index < PAGE_DEPTH) begin
               page_mem[seq_index] = data;
               seq_index++;
               effective = 1'b1;
               if (int'(seq_index) > filled_len) filled_len = int'(seq_index);
            end
         end
         snfcs_pkg::MODE_XFER: begin
            if (seq_phase != snfcs_pkg::PH_IDLE) exchange_completed(data);
         end
         default: ;
      endcase
      if (expected_results.size() > prior) begin
         expected_results[expected_results.size() - 1].last = 1'b1;
         effective = 1'b1;
      end
      return effective;
   endfunction

   // ------------------------------------------------------------------------
   // Response checker, receiver back-pressure and watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      flash_result_type exp_item;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected response: kind %0d, byte_value 0x%02h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            exp_item = expected_results.pop_front();
            if (rsp_tuser !== exp_item.kind) begin
               $error("kind mismatch: expected %0d, actual %0d", exp_item.kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata !== exp_item.value) begin
               $error("byte_value mismatch: expected 0x%02h, actual 0x%02h",
                      exp_item.value, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== exp_item.last) begin
               $error("last mismatch: expected %0b, actual %0b", exp_item.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Ends the run when no transaction moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // Called at a falling edge; returns at the falling edge after acceptance
   // with tvalid still high, so the caller drives the next cycle.
   task automatic send_item(input logic [1:0] mode, input logic [2:0] op,
                            input logic [23:0] addr, input logic [24:0] count,
                            input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0000, data, count, addr, op};
      do @(posedge clock); while (!req_tready);
      if (predict_item(mode, op, addr, count, data)) effective_items++;
      @(negedge clock);
   endtask

   // Waits for every expected result, then lets the pipeline settle.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_filler_byte(input logic [7:0] value);
      drain_pipeline();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we      <= 1'b0;
      filler_byte = value;
   endtask

   // A transaction that leaves a running operation where it is.
   task automatic send_noise();
      int          pick;
      logic [24:0] oversize;
      pick     = $urandom_range(3);
      oversize = 25'($urandom_range(25'h1FFFFFF, PAGE_DEPTH + 1));
      case (pick)
         0: send_item(snfcs_pkg::MODE_START,
                      (seq_phase == snfcs_pkg::PH_IDLE) ? OP_UNUSED : 3'($urandom),
                      24'($urandom), 25'($urandom), 8'($urandom));
         1: send_item(snfcs_pkg::MODE_LOAD, 3'($urandom), 24'($urandom), 25'($urandom),
                      8'($urandom));
         2: send_item(MODE_SPARE, 3'($urandom), 24'($urandom), 25'($urandom),
                      8'($urandom));
         default: begin
            if (seq_phase == snfcs_pkg::PH_IDLE) begin
               send_item(snfcs_pkg::MODE_XFER, 3'($urandom), 24'($urandom), 25'($urandom),
                         8'($urandom));
            end else begin
               send_item(snfcs_pkg::MODE_START, snfcs_pkg::OP_PROG, 24'($urandom), oversize,
                         8'($urandom));
            end
         end
      endcase
   endtask

   // Feeds byte exchanges until the running operation completes.
   task automatic run_sequence(input int busy_polls, input int noise_pct);
      int         polls;
      logic [7:0] rx;
      polls = 0;
      while (seq_phase != snfcs_pkg::PH_IDLE) begin
         if ($urandom_range(99) < noise_pct) begin
            send_noise();
         end else begin
            rx = 8'($urandom);
            if (seq_phase == snfcs_pkg::PH_POLL) begin
               rx[snfcs_pkg::STATUS_BUSY_BIT] = (polls < busy_polls);
               polls++;
            end
            send_item(snfcs_pkg::MODE_XFER, 3'($urandom), 24'($urandom), 25'($urandom), rx);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_identify();
      send_item(snfcs_pkg::MODE_START, snfcs_pkg::OP_ID, 24'h000000, 25'h0000000, 8'h00);
      run_sequence(0, 0);
   endtask

   task automatic test_filler_extremes();
      write_filler_byte(8'h00);
      send_item(snfcs_pkg::MODE_START, snfcs_pkg::OP_READ, 24'hFFFFFF, 25'd2, 8'hFF);
      run_sequence(0, 0);
      write_filler_byte(8'hFF);
      // Read of zero bytes: command and address only.
      send_item(snfcs_pkg::MODE_START, snfcs_pkg::OP_READ, 24'h000000, 25'd0, 8'h00);
      run_sequence(0, 0);
   endtask

   task automatic test_erase_and_status();
      write_filler_byte(8'($urandom));
      send_item(snfcs_pkg::MODE_START, snfcs_pkg::OP_WREN, 24'($urandom), 25'($urandom),
                8'($urandom));
      run_sequence(0, 0);
      send_item(snfcs_pkg::MODE_START, snfcs_pkg::OP_WAIT, 24'($urandom), 25'($urandom),
                8'($urandom));
      run_sequence(2, 0);
      send_item(snfcs_pkg::MODE_START, snfcs_pkg::OP_SERASE, 24'h123456, 25'h1FFFFFF, 8'h00);
      run_sequence(1, 0);
      send_item(snfcs_pkg::MODE_START, snfcs_pkg::OP_CERASE, 24'hFFFFFF, 25'h0000000, 8'hFF);
      run_sequence(0, 0);
   endtask

   task automatic test_program_cases();
      send_item(snfcs_pkg::MODE_LOAD, 3'd0, 24'd0, 25'd0, 8'h00);
      send_item(snfcs_pkg::MODE_LOAD, 3'd0, 24'd0, 25'd0, 8'hFF);
      send_item(snfcs_pkg::MODE_LOAD, 3'd0, 24'd0, 25'd0, 8'h5A);
      send_item(snfcs_pkg::MODE_START, snfcs_pkg::OP_PROG, 24'hFFFFFF, 25'd3, 8'h00);
      send_item(snfcs_pkg::MODE_XFER, 3'd0, 24'd0, 25'd0, 8'h00);
      // Start and load while busy: rejected and ignored.
      send_item(snfcs_pkg::MODE_START, snfcs_pkg::OP_ID, 24'd0, 25'd0, 8'h00);
      send_item(snfcs_pkg::MODE_LOAD, 3'd0, 24'd0, 25'd0, 8'hC3);
      run_sequence(1, 0);
      // Idle corner cases.
      send_item(snfcs_pkg::MODE_XFER, OP_UNUSED, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF);
      send_item(MODE_SPARE, OP_UNUSED, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF);
      send_item(snfcs_pkg::MODE_START, OP_UNUSED, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF);
      send_item(snfcs_pkg::MODE_START, snfcs_pkg::OP_PROG, 24'h000000, 25'(PAGE_DEPTH + 1),
                8'h00);
      send_item(snfcs_pkg::MODE_START, snfcs_pkg::OP_PROG, 24'h000000, 25'h1FFFFFF, 8'h00);
      send_item(snfcs_pkg::MODE_START, snfcs_pkg::OP_PROG, 24'h000000, 25'd0, 8'h00);
      run_sequence(0, 0);
   endtask

   // Fills the page past its end, then programs its head: a wrapping load
   // pointer would have overwritten the first entries.
   task automatic test_full_page();
      repeat (PAGE_DEPTH + 4) begin
         send_item(snfcs_pkg::MODE_LOAD, 3'($urandom), 24'($urandom), 25'($urandom),
                   8'($urandom));
      end
      send_item(snfcs_pkg::MODE_START, snfcs_pkg::OP_PROG, 24'($urandom), 25'd16,
                8'($urandom));
      run_sequence(1, 0);
   endtask

   task automatic test_random_traffic(input int goal, input int sender_pct,
                                      input int receiver_pct, input logic [7:0] filler);
      int          target;
      int          loads;
      logic [2:0]  op;
      logic [24:0] count;
      write_filler_byte(filler);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      target = effective_items + goal;
      while (effective_items < target) begin
         if ($urandom_range(99) < 12) begin
            send_noise();
         end else begin
            op    = 3'($urandom_range(snfcs_pkg::OP_READ));
            count = 25'($urandom);
            if (op == snfcs_pkg::OP_PROG) begin
               loads = $urandom_range(8);
               repeat (loads) begin
                  send_item(snfcs_pkg::MODE_LOAD, 3'($urandom), 24'($urandom),
                            25'($urandom), 8'($urandom));
               end
               if ($urandom_range(9) == 0) begin
                  count = 25'($urandom_range(25'h1FFFFFF, PAGE_DEPTH + 1));
               end else if (filled_len > 12) begin
                  count = 25'($urandom_range(12));
               end else begin
                  count = 25'($urandom_range(filled_len));
               end
            end else if (op == snfcs_pkg::OP_READ) begin
               count = ($urandom_range(15) == 0) ? 25'($urandom_range(40, 17))
                                                 : 25'($urandom_range(5));
            end
            send_item(snfcs_pkg::MODE_START, op, 24'($urandom), count, 8'($urandom));
            run_sequence($urandom_range(3), 8);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = '0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      seq_phase       = snfcs_pkg::PH_IDLE;
      seq_op          = '0;
      seq_addr        = '0;
      seq_index       = '0;
      seq_left        = '0;
      filler_byte     = snfcs_pkg::DUMMY_RESET;
      filled_len      = 0;
      effective_items = 0;
      send_idle_pct   = 6;
      recv_idle_pct   = 61;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_identify();
      test_filler_extremes();
      test_erase_and_status();
      test_program_cases();
      test_full_page();
      test_random_traffic(50, 6, 61, 8'($urandom));
      test_random_traffic(50, 61, 6, 8'h00);
      test_random_traffic(50, 0, 0, 8'hFF);

      drain_pipeline();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- spi_nor_flash_command_sequencer_unit.f -----
+incdir+rtl
rtl/snfcs_pkg.sv
rtl/snfcs_front.sv
rtl/snfcs_queue.sv
rtl/snfcs_back.sv
rtl/spi_nor_flash_command_sequencer_unit.sv
tb/sv/tb.sv
